FILE: hdl/hmbd_pkg.sv
// Shared types, constants and helper functions for the handheld bus decoder.
`default_nettype none

package hmbd_pkg;

    // Field widths
    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;

    // Store geometry
    localparam int VIDEO_DEPTH  = 8192;
    localparam int VIDEO_AW     = 13;
    localparam int WORK_DEPTH   = 8192;
    localparam int WORK_AW      = 13;
    localparam int SPRITE_DEPTH = 160;
    localparam int SPRITE_AW    = 8;
    localparam int HIGH_DEPTH   = 128;
    localparam int HIGH_AW      = 7;
    localparam int BOOT_DEPTH   = 256;
    localparam int BOOT_AW      = 8;
    localparam int IO_COUNT     = 76;
    localparam int IO_AW        = 7;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Address map
    localparam logic [ADDR_W-1:0] ECHO_DISTANCE = 16'h2000;
    localparam logic [ADDR_W-1:0] ECHO_LO       = 16'hE000;
    localparam logic [ADDR_W-1:0] ECHO_HI       = 16'hFDFF;
    localparam logic [ADDR_W-1:0] BOOT_HI       = 16'h00FF;
    localparam logic [ADDR_W-1:0] ROM_HI        = 16'h7FFF;
    localparam logic [ADDR_W-1:0] VIDEO_HI      = 16'h9FFF;
    localparam logic [ADDR_W-1:0] CART_RAM_LO   = 16'hA000;
    localparam logic [ADDR_W-1:0] CART_RAM_HI   = 16'hBFFF;
    localparam logic [ADDR_W-1:0] WORK_HI       = 16'hDFFF;
    localparam logic [ADDR_W-1:0] SPRITE_LO     = 16'hFE00;
    localparam logic [ADDR_W-1:0] SPRITE_HI     = 16'hFE9F;
    localparam logic [ADDR_W-1:0] IO_LO         = 16'hFF00;
    localparam logic [ADDR_W-1:0] IO_HI         = 16'hFF4B;
    localparam logic [ADDR_W-1:0] BOOT_OFF_ADDR = 16'hFF50;
    localparam logic [ADDR_W-1:0] HIGH_LO       = 16'hFF80;

    // I/O register indexes
    localparam logic [IO_AW-1:0] REG_JOYP = 7'h00;
    localparam logic [IO_AW-1:0] REG_SC   = 7'h02;
    localparam logic [IO_AW-1:0] REG_DIV  = 7'h04;
    localparam logic [IO_AW-1:0] REG_TAC  = 7'h07;
    localparam logic [IO_AW-1:0] REG_IF   = 7'h0F;
    localparam logic [IO_AW-1:0] REG_NR10 = 7'h10;
    localparam logic [IO_AW-1:0] REG_NR14 = 7'h14;
    localparam logic [IO_AW-1:0] REG_NR15 = 7'h15;
    localparam logic [IO_AW-1:0] REG_NR19 = 7'h19;
    localparam logic [IO_AW-1:0] REG_NR1A = 7'h1A;
    localparam logic [IO_AW-1:0] REG_NR1C = 7'h1C;
    localparam logic [IO_AW-1:0] REG_NR1E = 7'h1E;
    localparam logic [IO_AW-1:0] REG_NR1F = 7'h1F;
    localparam logic [IO_AW-1:0] REG_NR20 = 7'h20;
    localparam logic [IO_AW-1:0] REG_NR23 = 7'h23;
    localparam logic [IO_AW-1:0] REG_NR26 = 7'h26;
    localparam logic [IO_AW-1:0] REG_STAT = 7'h41;
    localparam logic [IO_AW-1:0] REG_LY   = 7'h44;
    localparam logic [IO_AW-1:0] REG_DMA  = 7'h46;

    // Write masks and joypad constants
    localparam logic [DATA_W-1:0] MASK_JOYP_SEL = 8'h30;
    localparam logic [DATA_W-1:0] OR_SC         = 8'h7E;
    localparam logic [DATA_W-1:0] OR_TAC        = 8'hF8;
    localparam logic [DATA_W-1:0] OR_IF         = 8'hE0;
    localparam logic [DATA_W-1:0] OR_TOP_BIT    = 8'h80;
    localparam logic [DATA_W-1:0] OR_FREQ_HI    = 8'hB8;
    localparam logic [DATA_W-1:0] OR_NR1A       = 8'h7F;
    localparam logic [DATA_W-1:0] OR_NR1C       = 8'h9F;
    localparam logic [DATA_W-1:0] OR_NR20       = 8'hC0;
    localparam logic [DATA_W-1:0] OR_NR23       = 8'hBF;
    localparam logic [DATA_W-1:0] OR_NR26       = 8'h70;
    localparam logic [DATA_W-1:0] ALL_ONES      = 8'hFF;
    localparam logic [DATA_W-1:0] JOY_ACTION    = 8'hD0;
    localparam logic [DATA_W-1:0] JOY_DIRECTION = 8'hE0;

    // Power-on values of registers FF00-FF4B
    localparam logic [DATA_W-1:0] IO_POWER_ON [IO_COUNT] = '{
        8'hCF, 8'h00, 8'h7E, 8'h00, 8'hAB, 8'h00, 8'h00, 8'hF8,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE1,
        8'h80, 8'hBF, 8'hF3, 8'hFF, 8'hBF, 8'h00, 8'h3F, 8'h00,
        8'hFF, 8'hBF, 8'h7F, 8'hFF, 8'h9F, 8'hFF, 8'hBF, 8'h00,
        8'hFF, 8'h00, 8'h00, 8'hBF, 8'h77, 8'hF3, 8'hF1, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h91, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFC,
        8'hFF, 8'hFF, 8'h00, 8'h00
    };

    typedef enum logic [1:0] {
        MODE_READ   = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_BUTTON = 2'd2,
        MODE_LOAD   = 2'd3
    } mode_t;

    // Destination class worked out by the front
    typedef enum logic [3:0] {
        KIND_NONE,
        KIND_CART,
        KIND_LOW,
        KIND_VIDEO,
        KIND_WORK,
        KIND_SPRITE,
        KIND_IO,
        KIND_HIGH,
        KIND_BOOT_OFF,
        KIND_BUTTON,
        KIND_LOAD
    } kind_t;

    // Source of read data at the end of the back
    typedef enum logic [2:0] {
        SRC_FIXED,
        SRC_VIDEO,
        SRC_WORK,
        SRC_SPRITE,
        SRC_HIGH,
        SRC_BOOT,
        SRC_IO
    } src_t;

    typedef struct packed {
        kind_t              kind;
        logic               wr;
        logic [ADDR_W-1:0]  addr;     // echo already folded down
        logic [DATA_W-1:0]  data;
        logic [2:0]         button;
        logic               released;
    } cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               cart_access;
        logic               cart_write;
        logic [ADDR_W-1:0]  cart_address;
        logic [DATA_W-1:0]  cart_data;
        logic               dma_start;
        logic [DATA_W-1:0]  dma_page;
        logic               joypad_irq;
        logic               status;
    } res_t;

    typedef struct packed {
        logic               keep;
        logic [DATA_W-1:0]  value;
    } io_wr_t;

    function automatic io_wr_t io_write_value(input logic [IO_AW-1:0] ridx,
                                              input logic [DATA_W-1:0] d);
        io_wr_t w;
        w.keep  = 1'b1;
        w.value = d;
        case (ridx)
            REG_JOYP: w.value = d & MASK_JOYP_SEL;
            REG_SC:   w.value = d | OR_SC;
            REG_DIV:  w.value = '0;
            REG_TAC:  w.value = d | OR_TAC;
            REG_IF:   w.value = d | OR_IF;
            REG_NR10,
            REG_STAT: w.value = d | OR_TOP_BIT;
            REG_NR14,
            REG_NR19,
            REG_NR1E: w.value = d | OR_FREQ_HI;
            REG_NR15,
            REG_NR1F: w.value = ALL_ONES;
            REG_NR1A: w.value = d | OR_NR1A;
            REG_NR1C: w.value = d | OR_NR1C;
            REG_NR20: w.value = d | OR_NR20;
            REG_NR23: w.value = d | OR_NR23;
            REG_NR26: w.value = d | OR_NR26;
            REG_LY,
            REG_DMA:  begin
                w.keep  = 1'b0;
                w.value = '0;
            end
            default:  w.value = d;
        endcase
        return w;
    endfunction

    function automatic logic [DATA_W-1:0] io_reset_value(input logic [IO_AW-1:0] ridx);
        logic [DATA_W-1:0] v;
        v = '0;
        if (ridx < IO_AW'(IO_COUNT))
        begin
            v = IO_POWER_ON[ridx];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hmbd_front.sv
// Front: accepts bus requests, folds the echo region and classifies the target.
`default_nettype none

module hmbd_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [1:0]                  mode,
    input  wire logic [hmbd_pkg::ADDR_W-1:0] address,
    input  wire logic [hmbd_pkg::DATA_W-1:0] data,
    input  wire logic [2:0]                  button,
    input  wire logic                        released,
    input  wire logic                        q_full,
    output logic                             q_push,
    output hmbd_pkg::cmd_t                   q_cmd
);

    logic                        valid_reg;
    logic                        valid_next;
    hmbd_pkg::cmd_t              cmd_reg;
    hmbd_pkg::cmd_t              cmd_next;
    logic                        accept;
    logic [hmbd_pkg::ADDR_W-1:0] addr_fold;
    logic                        is_wr;

    assign full   = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg && !q_full;
    assign q_cmd  = cmd_reg;

    always_comb
    begin
        is_wr = (hmbd_pkg::mode_t'(mode) == hmbd_pkg::MODE_WRITE);
        addr_fold = address;
        if (address >= hmbd_pkg::ECHO_LO && address <= hmbd_pkg::ECHO_HI)
        begin
            addr_fold = address - hmbd_pkg::ECHO_DISTANCE;
        end

        cmd_next.wr       = is_wr;
        cmd_next.addr     = addr_fold;
        cmd_next.data     = data;
        cmd_next.button   = button;
        cmd_next.released = released;

        case (hmbd_pkg::mode_t'(mode))
            hmbd_pkg::MODE_BUTTON: cmd_next.kind = hmbd_pkg::KIND_BUTTON;
            hmbd_pkg::MODE_LOAD:   cmd_next.kind = hmbd_pkg::KIND_LOAD;
            default:
            begin
                if (is_wr && addr_fold == hmbd_pkg::BOOT_OFF_ADDR)
                    cmd_next.kind = hmbd_pkg::KIND_BOOT_OFF;
                else if (addr_fold <= hmbd_pkg::BOOT_HI)
                    cmd_next.kind = hmbd_pkg::KIND_LOW;
                else if (addr_fold <= hmbd_pkg::ROM_HI
                         || (addr_fold >= hmbd_pkg::CART_RAM_LO
                             && addr_fold <= hmbd_pkg::CART_RAM_HI))
                    cmd_next.kind = hmbd_pkg::KIND_CART;
                else if (addr_fold <= hmbd_pkg::VIDEO_HI)
                    cmd_next.kind = hmbd_pkg::KIND_VIDEO;
                else if (addr_fold <= hmbd_pkg::WORK_HI)
                    cmd_next.kind = hmbd_pkg::KIND_WORK;
                else if (addr_fold >= hmbd_pkg::SPRITE_LO
                         && addr_fold <= hmbd_pkg::SPRITE_HI)
                    cmd_next.kind = hmbd_pkg::KIND_SPRITE;
                else if (addr_fold >= hmbd_pkg::IO_LO && addr_fold <= hmbd_pkg::IO_HI)
                    cmd_next.kind = hmbd_pkg::KIND_IO;
                else if (addr_fold >= hmbd_pkg::HIGH_LO)
                    cmd_next.kind = hmbd_pkg::KIND_HIGH;
                else
                    cmd_next.kind = hmbd_pkg::KIND_NONE;
            end
        endcase
    end

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (q_push)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

FILE: hdl/hmbd_queue.sv
// Short request queue between the front and the back.
`default_nettype none

module hmbd_queue #(
    parameter int DEPTH = hmbd_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire hmbd_pkg::cmd_t wr_cmd,
    output logic                full,
    input  wire logic           rd_en,
    output hmbd_pkg::cmd_t      rd_cmd,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hmbd_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

endmodule

`default_nettype wire

FILE: hdl/hmbd_back.sv
// Back: carries out requests against the stores and delivers one result per request.
`default_nettype none

module hmbd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_valid,
    input  wire logic           cfg_data,
    input  wire logic           q_empty,
    output logic                q_pop,
    input  wire hmbd_pkg::cmd_t cmd,
    input  wire logic           pop,
    output logic                empty,
    output hmbd_pkg::res_t      res
);

    // Stores
    logic [hmbd_pkg::DATA_W-1:0] video_mem  [hmbd_pkg::VIDEO_DEPTH];
    logic [hmbd_pkg::DATA_W-1:0] work_mem   [hmbd_pkg::WORK_DEPTH];
    logic [hmbd_pkg::DATA_W-1:0] sprite_mem [hmbd_pkg::SPRITE_DEPTH];
    logic [hmbd_pkg::DATA_W-1:0] high_mem   [hmbd_pkg::HIGH_DEPTH];
    logic [hmbd_pkg::DATA_W-1:0] boot_mem   [hmbd_pkg::BOOT_DEPTH];
    logic [hmbd_pkg::DATA_W-1:0] io_mem     [hmbd_pkg::IO_COUNT];

    logic [hmbd_pkg::DATA_W-1:0] video_q_reg;
    logic [hmbd_pkg::DATA_W-1:0] work_q_reg;
    logic [hmbd_pkg::DATA_W-1:0] sprite_q_reg;
    logic [hmbd_pkg::DATA_W-1:0] high_q_reg;
    logic [hmbd_pkg::DATA_W-1:0] boot_q_reg;
    logic [hmbd_pkg::DATA_W-1:0] io_q_reg;
    logic                        io_hit_q_reg;

    logic [hmbd_pkg::IO_COUNT-1:0] io_valid_reg;

    // Control state
    logic                        boot_present_reg;
    logic                        boot_off_reg;
    logic [1:0]                  sel_reg;
    logic [hmbd_pkg::DATA_W-1:0] buttons_reg;
    logic [hmbd_pkg::DATA_W-1:0] buttons_next;

    // Access stage and output stage
    logic                        a_valid_reg;
    hmbd_pkg::res_t              a_res_reg;
    hmbd_pkg::res_t              a_res_next;
    hmbd_pkg::src_t              a_src_reg;
    hmbd_pkg::src_t              a_src_next;
    logic [hmbd_pkg::IO_AW-1:0]  a_ridx_reg;
    logic                        o_valid_reg;
    hmbd_pkg::res_t              o_res_reg;
    hmbd_pkg::res_t              o_res_next;

    logic                        a_move;
    logic                        pop_ok;
    logic                        overlay;
    logic                        cart_go;
    logic [hmbd_pkg::IO_AW-1:0]  ridx;
    hmbd_pkg::io_wr_t            io_wr;
    logic [hmbd_pkg::DATA_W-1:0] btn_bit;
    logic                        rd_video;
    logic                        rd_work;
    logic                        rd_sprite;
    logic                        rd_high;
    logic                        rd_boot;
    logic                        rd_io;
    logic                        wr_load;
    logic                        wr_sel;
    logic                        wr_io;

    assign pop_ok = pop && o_valid_reg;
    assign a_move = a_valid_reg && (!o_valid_reg || pop_ok);
    assign q_pop  = !q_empty && (!a_valid_reg || a_move);
    assign empty  = !o_valid_reg;
    assign res    = o_res_reg;

    assign overlay = boot_present_reg && !boot_off_reg;
    assign ridx    = cmd.addr[hmbd_pkg::IO_AW-1:0];
    assign io_wr   = hmbd_pkg::io_write_value(ridx, cmd.data);
    assign btn_bit = hmbd_pkg::DATA_W'(1) << cmd.button;
    assign cart_go = (cmd.kind == hmbd_pkg::KIND_CART)
                     || (cmd.kind == hmbd_pkg::KIND_LOW && !overlay);

    assign rd_video  = q_pop && cmd.kind == hmbd_pkg::KIND_VIDEO;
    assign rd_work   = q_pop && cmd.kind == hmbd_pkg::KIND_WORK;
    assign rd_sprite = q_pop && cmd.kind == hmbd_pkg::KIND_SPRITE;
    assign rd_high   = q_pop && cmd.kind == hmbd_pkg::KIND_HIGH;
    assign rd_boot   = q_pop && cmd.kind == hmbd_pkg::KIND_LOW && overlay && !cmd.wr;
    assign wr_load   = q_pop && cmd.kind == hmbd_pkg::KIND_LOAD;
    assign rd_io     = q_pop && cmd.kind == hmbd_pkg::KIND_IO;
    assign wr_sel    = rd_io && cmd.wr && ridx == hmbd_pkg::REG_JOYP;
    assign wr_io     = rd_io && cmd.wr && ridx != hmbd_pkg::REG_JOYP && io_wr.keep;

    // Result fields known at issue; registered store data joins them on the way into the output stage
    always_comb
    begin
        a_res_next = '0;
        a_src_next = hmbd_pkg::SRC_FIXED;
        if (cart_go)
        begin
            a_res_next.cart_access  = 1'b1;
            a_res_next.cart_address = cmd.addr;
            if (cmd.wr)
            begin
                a_res_next.cart_write = 1'b1;
                a_res_next.cart_data  = cmd.data;
            end
        end
        case (cmd.kind)
            hmbd_pkg::KIND_BUTTON: a_res_next.joypad_irq = !cmd.released;
            hmbd_pkg::KIND_LOW:
            begin
                if (overlay && !cmd.wr)
                    a_src_next = hmbd_pkg::SRC_BOOT;
            end
            hmbd_pkg::KIND_VIDEO:
            begin
                if (!cmd.wr)
                    a_src_next = hmbd_pkg::SRC_VIDEO;
            end
            hmbd_pkg::KIND_WORK:
            begin
                if (!cmd.wr)
                    a_src_next = hmbd_pkg::SRC_WORK;
            end
            hmbd_pkg::KIND_SPRITE:
            begin
                if (!cmd.wr)
                    a_src_next = hmbd_pkg::SRC_SPRITE;
            end
            hmbd_pkg::KIND_HIGH:
            begin
                if (!cmd.wr)
                    a_src_next = hmbd_pkg::SRC_HIGH;
            end
            hmbd_pkg::KIND_IO:
            begin
                if (cmd.wr)
                begin
                    if (ridx == hmbd_pkg::REG_DMA)
                    begin
                        a_res_next.dma_start = 1'b1;
                        a_res_next.dma_page  = cmd.data;
                    end
                end
                else if (ridx == hmbd_pkg::REG_JOYP)
                begin
                    // sel_reg[0] is the action group, sel_reg[1] the directions
                    if (sel_reg[0])
                        a_res_next.read_data = hmbd_pkg::JOY_ACTION
                                               | {4'h0, buttons_reg[7:4]};
                    else if (sel_reg[1])
                        a_res_next.read_data = hmbd_pkg::JOY_DIRECTION
                                               | {4'h0, buttons_reg[3:0]};
                    else
                        a_res_next.status = 1'b1;
                end
                else
                begin
                    a_src_next = hmbd_pkg::SRC_IO;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        buttons_next = buttons_reg;
        if (q_pop && cmd.kind == hmbd_pkg::KIND_BUTTON)
        begin
            if (cmd.released)
                buttons_next = buttons_reg | btn_bit;
            else
                buttons_next = buttons_reg & ~btn_bit;
        end
    end

    always_comb
    begin
        o_res_next = a_res_reg;
        case (a_src_reg)
            hmbd_pkg::SRC_VIDEO:  o_res_next.read_data = video_q_reg;
            hmbd_pkg::SRC_WORK:   o_res_next.read_data = work_q_reg;
            hmbd_pkg::SRC_SPRITE: o_res_next.read_data = sprite_q_reg;
            hmbd_pkg::SRC_HIGH:   o_res_next.read_data = high_q_reg;
            hmbd_pkg::SRC_BOOT:   o_res_next.read_data = boot_q_reg;
            hmbd_pkg::SRC_IO:
                o_res_next.read_data = io_hit_q_reg ? io_q_reg
                                                    : hmbd_pkg::io_reset_value(a_ridx_reg);
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_present_reg <= 1'b0;
            boot_off_reg     <= 1'b0;
            sel_reg          <= '0;
            buttons_reg      <= hmbd_pkg::ALL_ONES;
            io_valid_reg     <= '0;
            a_valid_reg      <= 1'b0;
            o_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                boot_present_reg <= cfg_data;
            if (q_pop && cmd.kind == hmbd_pkg::KIND_BOOT_OFF)
                boot_off_reg <= 1'b1;
            if (wr_sel)
                sel_reg <= io_wr.value[5:4];
            if (wr_io)
                io_valid_reg[ridx] <= 1'b1;
            buttons_reg <= buttons_next;

            if (q_pop)
                a_valid_reg <= 1'b1;
            else if (a_move)
                a_valid_reg <= 1'b0;

            if (a_move)
                o_valid_reg <= 1'b1;
            else if (pop_ok)
                o_valid_reg <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_res_reg  <= a_res_next;
            a_src_reg  <= a_src_next;
            a_ridx_reg <= ridx;
        end
        if (a_move)
            o_res_reg <= o_res_next;
    end

    // Store ports: one access per request, read data registered
    always_ff @(posedge clk)
    begin
        if (rd_video)
        begin
            if (cmd.wr)
                video_mem[cmd.addr[hmbd_pkg::VIDEO_AW-1:0]] <= cmd.data;
            video_q_reg <= video_mem[cmd.addr[hmbd_pkg::VIDEO_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_work)
        begin
            if (cmd.wr)
                work_mem[cmd.addr[hmbd_pkg::WORK_AW-1:0]] <= cmd.data;
            work_q_reg <= work_mem[cmd.addr[hmbd_pkg::WORK_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_sprite)
        begin
            if (cmd.wr)
                sprite_mem[cmd.addr[hmbd_pkg::SPRITE_AW-1:0]] <= cmd.data;
            sprite_q_reg <= sprite_mem[cmd.addr[hmbd_pkg::SPRITE_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_high)
        begin
            if (cmd.wr)
                high_mem[cmd.addr[hmbd_pkg::HIGH_AW-1:0]] <= cmd.data;
            high_q_reg <= high_mem[cmd.addr[hmbd_pkg::HIGH_AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_load)
            boot_mem[cmd.addr[hmbd_pkg::BOOT_AW-1:0]] <= cmd.data;
        else if (rd_boot)
            boot_q_reg <= boot_mem[cmd.addr[hmbd_pkg::BOOT_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_io)
            io_mem[ridx] <= io_wr.value;
        else if (rd_io)
        begin
            io_q_reg     <= io_mem[ridx];
            io_hit_q_reg <= io_valid_reg[ridx];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/handheld_memory_bus_decoder_core.sv
// Top level of the handheld memory bus decoder.
//
// Usage notes
// - Request side is a queue interface: present mode/address/data/button/released
//   and raise push; the request is taken on a clock edge where push is high and
//   full is low.  Modes: read, write, button event, boot ROM byte load.
// - Result side is a queue too: while empty is low the oldest result sits on
//   read_data, cart_*, dma_*, joypad_irq and status; it is taken on an edge
//   where pop is high.  Every request gives exactly one result, in order.
// - Path: a taken request passes the front register, the request queue, the store
//   access stage and the output register, where the back forms the result.
// - Throughput: one request per cycle sustained while results are popped, set by
//   the single store access done per request in the back.
// - When the receiver stops popping, the output register, the access stage and
//   the two-entry request queue fill, and full rises until results are taken.
// - boot_rom_present is written through cfg_valid/cfg_data (cfg_ready is always
//   high); write it only while no request is in flight.
// - Reset clears all control state: buttons all released, boot overlay not yet
//   disabled, I/O registers read as their power-on values. No clearing pass runs;
//   the block takes requests as soon as reset is released.
`default_nettype none

module handheld_memory_bus_decoder_core #(
    parameter int QUEUE_DEPTH = hmbd_pkg::QUEUE_DEPTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic                        cfg_data,
    // requests
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [1:0]                  mode,
    input  wire logic [hmbd_pkg::ADDR_W-1:0] address,
    input  wire logic [hmbd_pkg::DATA_W-1:0] data,
    input  wire logic [2:0]                  button,
    input  wire logic                        released,
    // results
    output logic                             empty,
    input  wire logic                        pop,
    output logic [hmbd_pkg::DATA_W-1:0]      read_data,
    output logic                             cart_access,
    output logic                             cart_write,
    output logic [hmbd_pkg::ADDR_W-1:0]      cart_address,
    output logic [hmbd_pkg::DATA_W-1:0]      cart_data,
    output logic                             dma_start,
    output logic [hmbd_pkg::DATA_W-1:0]      dma_page,
    output logic                             joypad_irq,
    output logic                             status
);

    hmbd_pkg::cmd_t front_cmd;
    hmbd_pkg::cmd_t back_cmd;
    hmbd_pkg::res_t res;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;

    // Config writes are always taken; the block is idle by contract
    assign cfg_ready = 1'b1;

    hmbd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .mode     (mode),
        .address  (address),
        .data     (data),
        .button   (button),
        .released (released),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (front_cmd)
    );

    hmbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_cmd (front_cmd),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_cmd (back_cmd),
        .empty  (q_empty)
    );

    hmbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .cmd       (back_cmd),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    // Unpack result onto the individual ports
    assign read_data    = res.read_data;
    assign cart_access  = res.cart_access;
    assign cart_write   = res.cart_write;
    assign cart_address = res.cart_address;
    assign cart_data    = res.cart_data;
    assign dma_start    = res.dma_start;
    assign dma_page     = res.dma_page;
    assign joypad_irq   = res.joypad_irq;
    assign status       = res.status;

endmodule

`default_nettype wire

FILE: hdl/hmbd_checker.sv
// Port-level checks for the bus decoder, bound to the top level.
`default_nettype none

module hmbd_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_ready,
    input  wire logic                        full,
    input  wire logic                        empty,
    input  wire logic                        pop,
    input  wire logic [hmbd_pkg::DATA_W-1:0] read_data,
    input  wire logic                        cart_access,
    input  wire logic                        cart_write,
    input  wire logic                        dma_start,
    input  wire logic                        status
);

    // Straight out of reset nothing is waiting and requests are taken
    a_reset_clean: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full && cfg_ready))
        else $error("decoder not idle after reset");

    // A cartridge write is always a cartridge access
    a_cart_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && cart_write) |-> cart_access)
        else $error("cart_write without cart_access");

    // DMA requests come from an internal register write only
    a_dma_internal: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && dma_start) |-> (!cart_access && read_data == '0 && !status))
        else $error("dma_start mixed with other result fields");

    // Held result stays waiting, with read_data and status unchanged, while not taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(read_data) && $stable(status)))
        else $error("waiting result changed or vanished");

endmodule

bind handheld_memory_bus_decoder_core hmbd_checker u_checker (.*);

`default_nettype wire

FILE: tb/handheld_memory_bus_decoder_core_tb.sv
// Self-checking testbench for the handheld memory bus decoder core.
`default_nettype none

module handheld_memory_bus_decoder_core_tb;

    localparam int ADDR_BITS = hmbd_pkg::ADDR_W;
    localparam int DATA_BITS = hmbd_pkg::DATA_W;

    // Hard stop, several times the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Results taken before the receiver's long hold-off, and its length
    localparam int unsigned HOLD_AFTER  = 600;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_REPORTS = 40;
    localparam int unsigned POOL_DEPTH  = 48;

    // One bus request as the sender offers it
    typedef struct packed {
        hmbd_pkg::mode_t        mode;
        logic [ADDR_BITS-1:0]   address;
        logic [DATA_BITS-1:0]   data;
        logic [2:0]             button;
        logic                   released;
    } bus_request_t;

    // What the block should answer for one request
    typedef struct packed {
        logic [DATA_BITS-1:0]   read_data;
        logic                   cart_access;
        logic                   cart_write;
        logic [ADDR_BITS-1:0]   cart_address;
        logic [DATA_BITS-1:0]   cart_data;
        logic                   dma_start;
        logic [DATA_BITS-1:0]   dma_page;
        logic                   joypad_irq;
        logic                   status;
    } bus_reply_t;

    // ------------------------------------------------------------------
    // Clock, reset and block connections
    // ------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_data  = 1'b0;
    logic                   push      = 1'b0;
    logic [1:0]             mode      = '0;
    logic [ADDR_BITS-1:0]   address   = '0;
    logic [DATA_BITS-1:0]   data      = '0;
    logic [2:0]             button    = '0;
    logic                   released  = 1'b0;
    logic                   pop       = 1'b0;

    logic                   cfg_ready;
    logic                   full;
    logic                   empty;
    logic [DATA_BITS-1:0]   read_data;
    logic                   cart_access;
    logic                   cart_write;
    logic [ADDR_BITS-1:0]   cart_address;
    logic [DATA_BITS-1:0]   cart_data;
    logic                   dma_start;
    logic [DATA_BITS-1:0]   dma_page;
    logic                   joypad_irq;
    logic                   status;

    always #10 clk = ~clk;

    handheld_memory_bus_decoder_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .address      (address),
        .data         (data),
        .button       (button),
        .released     (released),
        .empty        (empty),
        .pop          (pop),
        .read_data    (read_data),
        .cart_access  (cart_access),
        .cart_write   (cart_write),
        .cart_address (cart_address),
        .cart_data    (cart_data),
        .dma_start    (dma_start),
        .dma_page     (dma_page),
        .joypad_irq   (joypad_irq),
        .status       (status)
    );

    // ------------------------------------------------------------------
    // Bus model: its own copy of every store and of the register
    // ------------------------------------------------------------------
    logic [DATA_BITS-1:0]   video_mem  [hmbd_pkg::VIDEO_DEPTH];
    logic [DATA_BITS-1:0]   work_mem   [hmbd_pkg::WORK_DEPTH];
    logic [DATA_BITS-1:0]   sprite_mem [hmbd_pkg::SPRITE_DEPTH];
    logic [DATA_BITS-1:0]   high_mem   [hmbd_pkg::HIGH_DEPTH];
    logic [DATA_BITS-1:0]   boot_bytes [hmbd_pkg::BOOT_DEPTH];
    logic [DATA_BITS-1:0]   io_file    [128];
    logic [DATA_BITS-1:0]   pad_bits;
    logic                   boot_flag_off;
    logic                   overlay_enable;

    bus_request_t           bus_requests[$];
    bus_reply_t             predicted_results[$];
    int unsigned            mismatches = 0;

    // Generator's view of what has been written, so that no request ever
    // reads a store entry that still holds nothing
    bit                     video_seen  [hmbd_pkg::VIDEO_DEPTH];
    bit                     work_seen   [hmbd_pkg::WORK_DEPTH];
    bit                     sprite_seen [hmbd_pkg::SPRITE_DEPTH];
    bit                     high_seen   [hmbd_pkg::HIGH_DEPTH];
    bit                     boot_seen   [hmbd_pkg::BOOT_DEPTH];
    logic [ADDR_BITS-1:0]   stored_addrs[$];
    logic [7:0]             boot_loaded[$];
    bit                     plan_boot_present = 1'b0;
    bit                     plan_boot_off     = 1'b0;

    function automatic logic [ADDR_BITS-1:0] fold_echo(input logic [ADDR_BITS-1:0] a);
        return (a >= hmbd_pkg::ECHO_LO && a <= hmbd_pkg::ECHO_HI)
               ? a - hmbd_pkg::ECHO_DISTANCE : a;
    endfunction

    // Works out the reply to one request and moves the model state on
    function automatic bus_reply_t decode_request(input bus_request_t req);
        bus_reply_t                 r;
        logic [ADDR_BITS-1:0]       a;
        logic [hmbd_pkg::IO_AW-1:0] idx;
        logic                       wr;
        r   = '0;
        a   = fold_echo(req.address);
        idx = a[hmbd_pkg::IO_AW-1:0];
        wr  = (req.mode == hmbd_pkg::MODE_WRITE);
        if (req.mode == hmbd_pkg::MODE_BUTTON)
        begin
            if (req.released)
            begin
                pad_bits = pad_bits | (8'd1 << req.button);
            end
            else
            begin
                pad_bits     = pad_bits & ~(8'd1 << req.button);
                r.joypad_irq = 1'b1;
            end
        end
        else if (req.mode == hmbd_pkg::MODE_LOAD)
        begin
            boot_bytes[req.address[7:0]] = req.data;
        end
        else if (wr && a == hmbd_pkg::BOOT_OFF_ADDR)
        begin
            boot_flag_off = 1'b1;
        end
        else if (a <= hmbd_pkg::BOOT_HI && overlay_enable && !boot_flag_off)
        begin
            // overlay: reads come from the boot image, writes vanish
            if (!wr)
            begin
                r.read_data = boot_bytes[a[7:0]];
            end
        end
        else if (a <= hmbd_pkg::ROM_HI
                 || (a >= hmbd_pkg::CART_RAM_LO && a <= hmbd_pkg::CART_RAM_HI))
        begin
            r.cart_access  = 1'b1;
            r.cart_address = a;
            if (wr)
            begin
                r.cart_write = 1'b1;
                r.cart_data  = req.data;
            end
        end
        else if (a <= hmbd_pkg::VIDEO_HI)
        begin
            if (wr) video_mem[a[hmbd_pkg::VIDEO_AW-1:0]] = req.data;
            else    r.read_data = video_mem[a[hmbd_pkg::VIDEO_AW-1:0]];
        end
        else if (a <= hmbd_pkg::WORK_HI)
        begin
            if (wr) work_mem[a[hmbd_pkg::WORK_AW-1:0]] = req.data;
            else    r.read_data = work_mem[a[hmbd_pkg::WORK_AW-1:0]];
        end
        else if (a >= hmbd_pkg::SPRITE_LO && a <= hmbd_pkg::SPRITE_HI)
        begin
            if (wr) sprite_mem[a[hmbd_pkg::SPRITE_AW-1:0]] = req.data;
            else    r.read_data = sprite_mem[a[hmbd_pkg::SPRITE_AW-1:0]];
        end
        else if (a >= hmbd_pkg::IO_LO && a <= hmbd_pkg::IO_HI)
        begin
            if (wr)
            begin
                case (idx)
                    hmbd_pkg::REG_JOYP: io_file[idx] = req.data & hmbd_pkg::MASK_JOYP_SEL;
                    hmbd_pkg::REG_SC:   io_file[idx] = req.data | hmbd_pkg::OR_SC;
                    hmbd_pkg::REG_DIV:  io_file[idx] = '0;
                    hmbd_pkg::REG_TAC:  io_file[idx] = req.data | hmbd_pkg::OR_TAC;
                    hmbd_pkg::REG_IF:   io_file[idx] = req.data | hmbd_pkg::OR_IF;
                    hmbd_pkg::REG_NR10,
                    hmbd_pkg::REG_STAT: io_file[idx] = req.data | hmbd_pkg::OR_TOP_BIT;
                    hmbd_pkg::REG_NR14,
                    hmbd_pkg::REG_NR19,
                    hmbd_pkg::REG_NR1E: io_file[idx] = req.data | hmbd_pkg::OR_FREQ_HI;
                    hmbd_pkg::REG_NR15,
                    hmbd_pkg::REG_NR1F: io_file[idx] = hmbd_pkg::ALL_ONES;
                    hmbd_pkg::REG_NR1A: io_file[idx] = req.data | hmbd_pkg::OR_NR1A;
                    hmbd_pkg::REG_NR1C: io_file[idx] = req.data | hmbd_pkg::OR_NR1C;
                    hmbd_pkg::REG_NR20: io_file[idx] = req.data | hmbd_pkg::OR_NR20;
                    hmbd_pkg::REG_NR23: io_file[idx] = req.data | hmbd_pkg::OR_NR23;
                    hmbd_pkg::REG_NR26: io_file[idx] = req.data | hmbd_pkg::OR_NR26;
                    hmbd_pkg::REG_LY:   ; // LY is read-only from the bus
                    hmbd_pkg::REG_DMA:
                    begin
                        r.dma_start = 1'b1;
                        r.dma_page  = req.data;
                    end
                    default:  io_file[idx] = req.data;
                endcase
            end
            else if (idx == hmbd_pkg::REG_JOYP)
            begin
                // action group wins when both selects are set
                if (io_file[hmbd_pkg::REG_JOYP][4])
                    r.read_data = hmbd_pkg::JOY_ACTION | {4'h0, pad_bits[7:4]};
                else if (io_file[hmbd_pkg::REG_JOYP][5])
                    r.read_data = hmbd_pkg::JOY_DIRECTION | {4'h0, pad_bits[3:0]};
                else
                    r.status = 1'b1;
            end
            else
            begin
                r.read_data = io_file[idx];
            end
        end
        else if (a >= hmbd_pkg::HIGH_LO)
        begin
            if (wr) high_mem[a[hmbd_pkg::HIGH_AW-1:0]] = req.data;
            else    r.read_data = high_mem[a[hmbd_pkg::HIGH_AW-1:0]];
        end
        // anything left is an unused hole: reads 0, writes ignored
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queues one request and notes which store entries it fills
    task automatic queue_request(input hmbd_pkg::mode_t m,
                                 input logic [ADDR_BITS-1:0] a,
                                 input logic [DATA_BITS-1:0] d, input logic [2:0] b,
                                 input logic r);
        bus_request_t           req;
        logic [ADDR_BITS-1:0]   f;
        req = '{mode: m, address: a, data: d, button: b, released: r};
        f   = fold_echo(a);
        if (m == hmbd_pkg::MODE_LOAD)
        begin
            boot_seen[a[7:0]] = 1'b1;
            boot_loaded.insert(boot_loaded.size(), a[7:0]);
        end
        else if (m == hmbd_pkg::MODE_WRITE)
        begin
            if (f == hmbd_pkg::BOOT_OFF_ADDR)
                plan_boot_off = 1'b1;
            else if (f > hmbd_pkg::ROM_HI && f <= hmbd_pkg::VIDEO_HI)
                video_seen[f[hmbd_pkg::VIDEO_AW-1:0]] = 1'b1;
            else if (f > hmbd_pkg::CART_RAM_HI && f <= hmbd_pkg::WORK_HI)
                work_seen[f[hmbd_pkg::WORK_AW-1:0]] = 1'b1;
            else if (f >= hmbd_pkg::SPRITE_LO && f <= hmbd_pkg::SPRITE_HI)
                sprite_seen[f[hmbd_pkg::SPRITE_AW-1:0]] = 1'b1;
            else if (f >= hmbd_pkg::HIGH_LO)
                high_seen[f[hmbd_pkg::HIGH_AW-1:0]] = 1'b1;
            if ((f > hmbd_pkg::ROM_HI && f <= hmbd_pkg::VIDEO_HI)
                || (f > hmbd_pkg::CART_RAM_HI && f <= hmbd_pkg::WORK_HI)
                || (f >= hmbd_pkg::SPRITE_LO && f <= hmbd_pkg::SPRITE_HI)
                || f >= hmbd_pkg::HIGH_LO)
            begin
                stored_addrs.insert(stored_addrs.size(), f);
                if (stored_addrs.size() > POOL_DEPTH)
                    void'(stored_addrs.pop_front());
            end
        end
        bus_requests.insert(bus_requests.size(), req);
    endtask

    // Random requests weighted towards the interesting parts of the map.
    // Reads lean on addresses already written; a read that would hit an
    // empty entry becomes a write to it instead.
    task automatic queue_random(input int unsigned count, input bit allow_boot_off);
        bus_request_t           req;
        logic [ADDR_BITS-1:0]   f;
        bit                     safe;
        int unsigned            n;
        for (n = 0; n < count; n++)
        begin
            req.address  = ADDR_BITS'($urandom);
            req.data     = DATA_BITS'($urandom);
            req.button   = 3'($urandom);
            req.released = 1'($urandom);
            case ($urandom_range(0, 19))
                0, 1:    req.mode = hmbd_pkg::MODE_BUTTON;
                2:       req.mode = hmbd_pkg::MODE_LOAD;
                3, 4, 5, 6, 7, 8, 9, 10:
                         req.mode = hmbd_pkg::MODE_READ;
                default: req.mode = hmbd_pkg::MODE_WRITE;
            endcase
            if (req.mode == hmbd_pkg::MODE_READ || req.mode == hmbd_pkg::MODE_WRITE)
            begin
                case ($urandom_range(0, 15))
                    0:
                    begin
                        if (req.mode == hmbd_pkg::MODE_READ && boot_loaded.size() != 0 &&
                            $urandom_range(0, 1) == 1)
                            req.address = {8'h00,
                                boot_loaded[$urandom_range(0, boot_loaded.size() - 1)]};
                        else
                            req.address = ADDR_BITS'($urandom_range(0, hmbd_pkg::BOOT_HI));
                    end
                    1:      req.address = ADDR_BITS'($urandom_range(0, hmbd_pkg::ROM_HI));
                    2:      req.address = ADDR_BITS'($urandom_range(hmbd_pkg::CART_RAM_LO,
                                                                    hmbd_pkg::CART_RAM_HI));
                    3, 4:   req.address = ADDR_BITS'($urandom_range(hmbd_pkg::ROM_HI + 1,
                                                                    hmbd_pkg::VIDEO_HI));
                    5, 6:   req.address = ADDR_BITS'($urandom_range(hmbd_pkg::CART_RAM_HI + 1,
                                                                    hmbd_pkg::WORK_HI));
                    7:      req.address = ADDR_BITS'($urandom_range(hmbd_pkg::ECHO_LO,
                                                                    hmbd_pkg::ECHO_HI));
                    8:      req.address = ADDR_BITS'($urandom_range(hmbd_pkg::SPRITE_LO,
                                                                    hmbd_pkg::SPRITE_HI));
                    9:
                    begin
                        if ($urandom_range(0, 1) == 1)
                            req.address = ADDR_BITS'($urandom_range(hmbd_pkg::SPRITE_HI + 1,
                                                                    hmbd_pkg::IO_LO - 1));
                        else
                            req.address = ADDR_BITS'($urandom_range(hmbd_pkg::IO_HI + 1,
                                                                    hmbd_pkg::HIGH_LO - 1));
                    end
                    10, 11: req.address = ADDR_BITS'($urandom_range(hmbd_pkg::IO_LO,
                                                                    hmbd_pkg::IO_HI));
                    12:
                    begin
                        // joypad, DMA, LY, DIV and boot disable get extra visits
                        case ($urandom_range(0, 5))
                            0, 1:    req.address = hmbd_pkg::IO_LO
                                                   + ADDR_BITS'(hmbd_pkg::REG_JOYP);
                            2:       req.address = hmbd_pkg::IO_LO
                                                   + ADDR_BITS'(hmbd_pkg::REG_DMA);
                            3:       req.address = hmbd_pkg::IO_LO
                                                   + ADDR_BITS'(hmbd_pkg::REG_LY);
                            4:       req.address = hmbd_pkg::IO_LO
                                                   + ADDR_BITS'(hmbd_pkg::REG_DIV);
                            default: req.address = hmbd_pkg::BOOT_OFF_ADDR;
                        endcase
                    end
                    13:     req.address = ADDR_BITS'($urandom_range(hmbd_pkg::HIGH_LO,
                                                                    16'hFFFF));
                    default:
                    begin
                        if (req.mode == hmbd_pkg::MODE_READ && stored_addrs.size() != 0)
                        begin
                            f = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
                            // work RAM entries up to DDFF are reached through the echo half the time
                            if (f > hmbd_pkg::CART_RAM_HI
                                && f <= hmbd_pkg::ECHO_HI - hmbd_pkg::ECHO_DISTANCE
                                && $urandom_range(0, 1) == 1)
                                f = f + hmbd_pkg::ECHO_DISTANCE;
                            req.address = f;
                        end
                    end
                endcase
            end
            f = fold_echo(req.address);
            if (req.mode == hmbd_pkg::MODE_WRITE && f == hmbd_pkg::BOOT_OFF_ADDR
                && !allow_boot_off)
                req.mode = hmbd_pkg::MODE_READ;
            if (f <= hmbd_pkg::BOOT_HI && plan_boot_present && !plan_boot_off)
                safe = boot_seen[f[7:0]];
            else if (f > hmbd_pkg::ROM_HI && f <= hmbd_pkg::VIDEO_HI)
                safe = video_seen[f[hmbd_pkg::VIDEO_AW-1:0]];
            else if (f > hmbd_pkg::CART_RAM_HI && f <= hmbd_pkg::WORK_HI)
                safe = work_seen[f[hmbd_pkg::WORK_AW-1:0]];
            else if (f >= hmbd_pkg::SPRITE_LO && f <= hmbd_pkg::SPRITE_HI)
                safe = sprite_seen[f[hmbd_pkg::SPRITE_AW-1:0]];
            else if (f >= hmbd_pkg::HIGH_LO)
                safe = high_seen[f[hmbd_pkg::HIGH_AW-1:0]];
            else
                safe = 1'b1;
            if (req.mode == hmbd_pkg::MODE_READ && !safe)
                req.mode = hmbd_pkg::MODE_WRITE;
            queue_request(req.mode, req.address, req.data, req.button, req.released);
        end
    endtask

    // Blocks until every queued request has been taken and answered
    task automatic wait_idle();
        while (bus_requests.size() != 0 || push || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write over the config channel; block must be idle
    task automatic set_boot_present(input logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid         <= 1'b0;
        overlay_enable    = v;
        plan_boot_present = v;
    endtask

    task automatic check_field(input string name, input logic [ADDR_BITS-1:0] want,
                               input logic [ADDR_BITS-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: offers the oldest pending request, pausing at random between
    // requests, with runs of back-to-back requests
    // ------------------------------------------------------------------
    int unsigned send_wait;
    bit          send_burst;
    bit          taken;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push       <= 1'b0;
            send_wait  = 0;
            send_burst = 1'b0;
        end
        else
        begin
            taken = push && !full;
            if (taken)
            begin
                // request taken at this edge: predict its reply now
                predicted_results.insert(predicted_results.size(),
                                         decode_request(bus_requests.pop_front()));
                send_wait = send_burst ? 0 : $urandom_range(0, 9);
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
            end
            else if (!push && send_wait > 0)
            begin
                send_wait--;
            end
            // a stalled request stays on the ports untouched
            if (taken || !push)
            begin
                if (send_wait == 0 && bus_requests.size() != 0)
                begin
                    push     <= 1'b1;
                    mode     <= bus_requests[0].mode;
                    address  <= bus_requests[0].address;
                    data     <= bus_requests[0].data;
                    button   <= bus_requests[0].button;
                    released <= bus_requests[0].released;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: pops replies with random stalls, plus one long hold-off
    // so that the block backs up and raises full
    // ------------------------------------------------------------------
    int unsigned take_wait;
    int unsigned pops_seen;
    int unsigned hold_left;
    bit          hold_done;
    bit          recv_burst;
    bus_reply_t  want;

    // Long hold-off, counted in cycles once enough results have been taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pops_seen <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
                pops_seen <= pops_seen + 1;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && pops_seen >= HOLD_AFTER)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop        <= 1'b0;
            take_wait  = 0;
            recv_burst = 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: reply with no request outstanding, read_data %h",
                                 $time, read_data);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    check_field("read_data",    want.read_data,    read_data);
                    check_field("cart_access",  want.cart_access,  cart_access);
                    check_field("cart_write",   want.cart_write,   cart_write);
                    check_field("cart_address", want.cart_address, cart_address);
                    check_field("cart_data",    want.cart_data,    cart_data);
                    check_field("dma_start",    want.dma_start,    dma_start);
                    check_field("dma_page",     want.dma_page,     dma_page);
                    check_field("joypad_irq",   want.joypad_irq,   joypad_irq);
                    check_field("status",       want.status,       status);
                end
                take_wait = recv_burst ? 0 : $urandom_range(0, 9);
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
            end
            else if (take_wait > 0)
            begin
                take_wait--;
            end
            pop <= (hold_left == 0 && take_wait == 0);
        end
    end

    // Watchdog
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("handheld_memory_bus_decoder_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int i;
        for (i = 0; i < 128; i++)
            io_file[i] = (i < hmbd_pkg::IO_COUNT) ? hmbd_pkg::IO_POWER_ON[i] : '0;
        pad_bits       = hmbd_pkg::ALL_ONES;
        boot_flag_off  = 1'b0;
        overlay_enable = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Overlay on: directed corners first
        set_boot_present(1'b1);
        queue_request(hmbd_pkg::MODE_LOAD,  16'h1200, 8'hA5, 3'd0, 1'b0); // index from low byte
        queue_request(hmbd_pkg::MODE_LOAD,  16'hFFFF, 8'h5A, 3'd7, 1'b1);
        queue_request(hmbd_pkg::MODE_READ,  16'h0000, 8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_READ,  16'h00FF, 8'hFF, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE, 16'h0080, 8'h33, 3'd0, 1'b0); // dropped by overlay
        queue_request(hmbd_pkg::MODE_READ,  16'h0100, 8'h00, 3'd0, 1'b0); // past the overlay
        queue_request(hmbd_pkg::MODE_WRITE, 16'h7FFF, 8'hFF, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE, 16'h9FFF, 8'hFF, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_READ,  16'h9FFF, 8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE, 16'hFDFF, 8'hC3, 3'd0, 1'b0); // echo write
        queue_request(hmbd_pkg::MODE_READ,  16'hDDFF, 8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE, 16'hFE9F, 8'h55, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_READ,  16'hFE9F, 8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_READ,  16'hFEA0, 8'h00, 3'd0, 1'b0); // unused hole
        queue_request(hmbd_pkg::MODE_READ,  16'hFF4C, 8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE, 16'hFFFF, 8'h77, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_READ,  16'hFFFF, 8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE,
                      hmbd_pkg::IO_LO + ADDR_BITS'(hmbd_pkg::REG_DMA), 8'hC1, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE,
                      hmbd_pkg::IO_LO + ADDR_BITS'(hmbd_pkg::REG_LY),  8'h12, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_READ,
                      hmbd_pkg::IO_LO + ADDR_BITS'(hmbd_pkg::REG_LY),  8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_BUTTON, 16'h0000, 8'h00, 3'd7, 1'b0); // press start
        queue_request(hmbd_pkg::MODE_WRITE, hmbd_pkg::IO_LO, 8'h10, 3'd0, 1'b0); // action group
        queue_request(hmbd_pkg::MODE_READ,  hmbd_pkg::IO_LO, 8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE, hmbd_pkg::IO_LO, 8'h20, 3'd0, 1'b0); // directions
        queue_request(hmbd_pkg::MODE_READ,  hmbd_pkg::IO_LO, 8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE, hmbd_pkg::IO_LO, 8'h00, 3'd0, 1'b0); // no group
        queue_request(hmbd_pkg::MODE_READ,  hmbd_pkg::IO_LO, 8'h00, 3'd0, 1'b0);
        queue_random(350, 1'b0);
        wait_idle();

        // Overlay off by register, boot flag still clear
        set_boot_present(1'b0);
        queue_random(350, 1'b0);
        wait_idle();

        // Overlay back on, then disabled for good by a write to the boot flag
        set_boot_present(1'b1);
        queue_request(hmbd_pkg::MODE_READ,  16'h0000, 8'h00, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_WRITE, hmbd_pkg::BOOT_OFF_ADDR, 8'h01, 3'd0, 1'b0);
        queue_request(hmbd_pkg::MODE_READ,  16'h0000, 8'h00, 3'd0, 1'b0);
        queue_random(400, 1'b1);
        wait_idle();

        set_boot_present(1'b0);
        queue_random(400, 1'b1);
        wait_idle();

        // let any stray reply show up before judging
        repeat (8) @(posedge clk);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("handheld_memory_bus_decoder_core test passed");
        else
            $display("handheld_memory_bus_decoder_core test failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: handheld_memory_bus_decoder_core.f
hdl/hmbd_pkg.sv
hdl/hmbd_front.sv
hdl/hmbd_queue.sv
hdl/hmbd_back.sv
hdl/handheld_memory_bus_decoder_core.sv
hdl/hmbd_checker.sv
tb/handheld_memory_bus_decoder_core_tb.sv
